// ===== rtl/core/bfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared constants, types and arithmetic helpers for the bilateral filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bfr_pkg;

  localparam int RADIUS     = 5;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1048576;
  localparam int DEPTH      = (2 * RADIUS + 1) * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
  localparam int RAD_W      = $clog2(RADIUS + 1);
  localparam int OFF_W      = RAD_W + 1;
  localparam int SD_W       = $clog2(2 * RADIUS * RADIUS + 1);
  localparam int SX_W       = SD_W + 16;
  localparam int D2_W       = 18;
  localparam int RX_W       = D2_W + 16 + 1 - 8;
  localparam int WSUM_W     = 32;
  localparam int SUM_W      = 40;
  localparam int NUM_W      = SUM_W + 1;
  localparam int DV_W       = WSUM_W + 7;
  localparam int EXP_LIMIT  = 3072;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_COEF = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_COEF   = CFG_IDX_W'(3);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [23:0] bfr_pixel_t;

  typedef struct packed {
    logic              wr;
    bfr_pixel_t        px;
    logic [ADDR_W-1:0] wr_addr;
    logic              cmp;
    logic [ADDR_W-1:0] ctr_addr;
    logic [RAD_W-1:0]  up;
    logic [RAD_W-1:0]  down;
    logic [RAD_W-1:0]  left;
    logic [RAD_W-1:0]  right;
    logic              last;
  } bfr_job_t;

  function automatic logic [15:0] rmul(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] p;
    p = 32'(a) * 32'(b) + 32'd32768;
    return p[31:16];
  endfunction

  function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ADDR_W+1)'(DEPTH)) s = s - (ADDR_W+1)'(DEPTH);
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] addr_sub(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else s = {1'b0, a} + (ADDR_W+1)'(DEPTH) - {1'b0, b};
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [15:0] exp_int(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0: v = 16'd65535;
      4'd1: v = 16'd24109;
      4'd2: v = 16'd8869;
      4'd3: v = 16'd3263;
      4'd4: v = 16'd1200;
      4'd5: v = 16'd442;
      4'd6: v = 16'd162;
      4'd7: v = 16'd60;
      4'd8: v = 16'd22;
      4'd9: v = 16'd8;
      4'd10: v = 16'd3;
      4'd11: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] exp_hi(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0: v = 16'd65535;
      4'd1: v = 16'd61565;
      4'd2: v = 16'd57835;
      4'd3: v = 16'd54331;
      4'd4: v = 16'd51039;
      4'd5: v = 16'd47947;
      4'd6: v = 16'd45042;
      4'd7: v = 16'd42313;
      4'd8: v = 16'd39750;
      4'd9: v = 16'd37341;
      4'd10: v = 16'd35079;
      4'd11: v = 16'd32954;
      4'd12: v = 16'd30957;
      4'd13: v = 16'd29081;
      4'd14: v = 16'd27319;
      default: v = 16'd25664;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] exp_lo(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0: v = 16'd65535;
      4'd1: v = 16'd65280;
      4'd2: v = 16'd65026;
      4'd3: v = 16'd64772;
      4'd4: v = 16'd64520;
      4'd5: v = 16'd64268;
      4'd6: v = 16'd64018;
      4'd7: v = 16'd63768;
      4'd8: v = 16'd63520;
      4'd9: v = 16'd63272;
      4'd10: v = 16'd63025;
      4'd11: v = 16'd62780;
      4'd12: v = 16'd62535;
      4'd13: v = 16'd62291;
      4'd14: v = 16'd62048;
      default: v = 16'd61806;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bfr_ifs.sv =====
// ----------------------------------------------------------------------------
// bfr_ifs
// Channel interfaces: pixel items in, filtered items out, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;
  modport source(output valid, operation, blue_in, green_in, red_in, input ready);
  modport sink(input valid, operation, blue_in, green_in, red_in, output ready);
endinterface

interface bfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       frame_last;
  modport source(output valid, blue_out, green_out, red_out, frame_last, input ready);
  modport sink(input valid, blue_out, green_out, red_out, frame_last, output ready);
endinterface

interface bfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfr_front.sv =====
// ----------------------------------------------------------------------------
// bfr_front
// Accepts items, tracks input and output positions, issues store and window jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module bfr_front (
  input  logic             clk,
  input  logic             rst,
  bfr_in_if.sink           pixels,
  input  logic [bfr_pkg::COL_W-1:0] width,
  input  logic [bfr_pkg::ROW_W-1:0] height,
  input  logic             q_full,
  output logic             q_push,
  output bfr_pkg::bfr_job_t q_job
);
  import bfr_pkg::*;

  logic [COL_W-1:0]  in_column, out_column;
  logic [ROW_W-1:0]  in_row, out_row;
  logic [ADDR_W-1:0] in_addr, out_addr;

  logic              acc, complete, is_pix, rdy, wr, last;
  logic [ROW_W:0]    orr;
  logic [COL_W:0]    occ;
  logic [ROW_W-1:0]  hm1, rr;
  logic [COL_W-1:0]  wm1, cc;
  logic              row_past, row_at;
  logic [COL_W-1:0]  in_col_inc, out_col_inc;
  logic [ROW_W-1:0]  out_row_inc;

  assign pixels.ready = !q_full;
  assign acc = pixels.valid && pixels.ready;

  always_comb begin
    hm1 = height - ROW_W'(1);
    wm1 = width - COL_W'(1);
    orr = {1'b0, out_row} + (ROW_W+1)'(RADIUS);
    occ = {1'b0, out_column} + (COL_W+1)'(RADIUS);
    rr = (orr > {1'b0, hm1}) ? hm1 : orr[ROW_W-1:0];
    cc = (occ > {1'b0, wm1}) ? wm1 : occ[COL_W-1:0];
    complete = in_row >= height;
    is_pix = (pixels.operation == OP_PIXEL) && !complete;
    row_past = in_row > rr;
    row_at = in_row == rr;
    if (is_pix) rdy = row_past || (row_at && in_column >= cc);
    else rdy = complete || row_past || (row_at && in_column > cc);
    in_col_inc = in_column + COL_W'(1);
    out_col_inc = out_column + COL_W'(1);
    out_row_inc = out_row + ROW_W'(1);
    last = (out_col_inc >= width) && (out_row_inc >= height);
    wr = is_pix && !(rdy && last);
    q_push = acc && (wr || rdy);

    q_job.wr = is_pix;
    q_job.px = {pixels.red_in, pixels.green_in, pixels.blue_in};
    q_job.wr_addr = in_addr;
    q_job.cmp = rdy;
    q_job.ctr_addr = out_addr;
    q_job.up = (out_row > ROW_W'(RADIUS)) ? RAD_W'(RADIUS) : RAD_W'(out_row);
    q_job.left = (out_column > COL_W'(RADIUS)) ? RAD_W'(RADIUS) : RAD_W'(out_column);
    q_job.down = (orr > {1'b0, hm1}) ? RAD_W'(hm1 - out_row) : RAD_W'(RADIUS);
    q_job.right = (occ > {1'b0, wm1}) ? RAD_W'(wm1 - out_column) : RAD_W'(RADIUS);
    q_job.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row <= '0;
      in_addr <= '0;
      out_column <= '0;
      out_row <= '0;
      out_addr <= '0;
    end else if (acc) begin
      if (rdy && last) begin
        in_column <= '0;
        in_row <= '0;
        in_addr <= '0;
        out_column <= '0;
        out_row <= '0;
        out_addr <= '0;
      end else begin
        if (wr) begin
          in_addr <= addr_add(in_addr, ADDR_W'(1));
          if (in_col_inc >= width) begin
            in_column <= '0;
            in_row <= in_row + ROW_W'(1);
          end else begin
            in_column <= in_col_inc;
          end
        end
        if (rdy) begin
          out_addr <= addr_add(out_addr, ADDR_W'(1));
          if (out_col_inc >= width) begin
            out_column <= '0;
            out_row <= out_row_inc;
          end else begin
            out_column <= out_col_inc;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bfr_queue.sv =====
// ----------------------------------------------------------------------------
// bfr_queue
// Short job queue between the front and the window engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bfr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bfr_pkg::bfr_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output bfr_pkg::bfr_job_t pop_job
);
  import bfr_pkg::*;

  bfr_job_t          entries [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QPTR_W:0]   count;

  assign full = count == (QPTR_W+1)'(QDEPTH);
  assign not_empty = count != '0;
  assign pop_job = entries[rp];

  always_ff @(posedge clk) begin
    if (push) entries[wp] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + QPTR_W'(1);
      if (pop) rp <= rp + QPTR_W'(1);
      case ({push, pop})
        2'b10: count <= count + (QPTR_W+1)'(1);
        2'b01: count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bfr_back.sv =====
// ----------------------------------------------------------------------------
// bfr_back
// Pixel store, window scan, weight pipeline, accumulators and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bfr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  bfr_pkg::bfr_job_t job,
  output logic              q_pop,
  input  logic [bfr_pkg::COL_W-1:0] width,
  input  logic [15:0]       spatial_coef,
  input  logic [15:0]       range_coef,
  bfr_out_if.source         results
);
  import bfr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_UP, S_SCAN, S_DRAIN, S_DIV, S_EMIT} state_t;

  state_t                state;
  bfr_pixel_t            mem [DEPTH];
  bfr_pixel_t            mem_q;
  logic [ADDR_W-1:0]     raddr;

  bfr_job_t              cur_job;
  bfr_pixel_t            ctr;
  logic                  ctr_take;
  logic [ADDR_W-1:0]     row_addr, cur_addr;
  logic [RAD_W-1:0]      cnt;
  logic signed [OFF_W-1:0] dx, dy;

  logic                  v0, v1, v2, v3, v4, v5;
  logic signed [OFF_W-1:0] dx0, dy0;
  bfr_pixel_t            px1, px2, px3, px4, px5;
  logic [D2_W-1:0]       d2_1;
  logic [SD_W-1:0]       sd1;
  logic [SX_W-1:0]       sx2;
  logic [RX_W-1:0]       rx2;
  logic [15:0]           as3, ar3, es4, er4, wt5;
  logic                  zs3, zr3;
  logic [3:0]            ls3, lr3;

  logic [WSUM_W-1:0]     wsum;
  logic [SUM_W-1:0]      sum [3];
  logic [NUM_W-1:0]      rem [3];
  logic [7:0]            qv [3];
  logic [2:0]            sat;
  logic [DV_W-1:0]       dv;
  logic [2:0]            step;
  logic                  zero;

  logic [D2_W-1:0]       d2_c;
  logic [OFF_W-2:0]      ax, ay;
  logic                  busy;
  logic signed [OFF_W-1:0] right_s, down_s;
  logic [NUM_W-1:0]      num [3];
  logic [7:0]            res [3];

  assign q_pop = (state == S_IDLE) && q_valid;
  assign raddr = (state == S_SCAN) ? cur_addr : cur_job.ctr_addr;
  assign busy = v0 || v1 || v2 || v3 || v4 || v5;
  assign right_s = $signed({1'b0, cur_job.right});
  assign down_s = $signed({1'b0, cur_job.down});

  always_comb begin
    d2_c = '0;
    for (int k = 0; k < 3; k++) begin
      logic signed [8:0] d;
      d = $signed({1'b0, mem_q[8*k +: 8]}) - $signed({1'b0, ctr[8*k +: 8]});
      d2_c = d2_c + D2_W'(unsigned'(18'(d * d)));
    end
    ax = dx0[OFF_W-1] ? (OFF_W-1)'(-dx0) : (OFF_W-1)'(dx0);
    ay = dy0[OFF_W-1] ? (OFF_W-1)'(-dy0) : (OFF_W-1)'(dy0);
    for (int k = 0; k < 3; k++) begin
      num[k] = {1'b0, sum[k]} + NUM_W'(wsum >> 1);
      if (zero) res[k] = 8'd0;
      else if (sat[k]) res[k] = 8'd255;
      else res[k] = qv[k];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && job.wr) mem[job.wr_addr] <= job.px;
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    dx0 <= dx;
    dy0 <= dy;
    px1 <= mem_q;
    d2_1 <= d2_c;
    sd1 <= SD_W'(ax * ax) + SD_W'(ay * ay);
    px2 <= px1;
    sx2 <= SX_W'(sd1) * SX_W'(spatial_coef);
    rx2 <= RX_W'((35'(d2_1) * 35'(range_coef) + 35'd128) >> 8);
    px3 <= px2;
    as3 <= rmul(exp_int(sx2[11:8]), exp_hi(sx2[7:4]));
    ar3 <= rmul(exp_int(rx2[11:8]), exp_hi(rx2[7:4]));
    zs3 <= sx2 >= SX_W'(EXP_LIMIT);
    zr3 <= rx2 >= RX_W'(EXP_LIMIT);
    ls3 <= sx2[3:0];
    lr3 <= rx2[3:0];
    px4 <= px3;
    es4 <= zs3 ? 16'd0 : rmul(as3, exp_lo(ls3));
    er4 <= zr3 ? 16'd0 : rmul(ar3, exp_lo(lr3));
    px5 <= px4;
    wt5 <= rmul(es4, er4);
    if (ctr_take) ctr <= mem_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctr_take <= 1'b0;
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      ctr_take <= state == S_PREP;
      v0 <= state == S_SCAN;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (v5) begin
        wsum <= wsum + WSUM_W'(wt5);
        for (int k = 0; k < 3; k++) sum[k] <= sum[k] + SUM_W'(24'(wt5) * 24'(px5[8*k +: 8]));
      end
      if (results.valid && results.ready && state != S_EMIT) results.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && job.cmp) begin
            cur_job <= job;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          row_addr <= addr_sub(cur_job.ctr_addr, ADDR_W'(cur_job.left));
          cnt <= cur_job.up;
          wsum <= '0;
          for (int k = 0; k < 3; k++) sum[k] <= '0;
          state <= S_UP;
        end
        S_UP: begin
          if (cnt != '0) begin
            row_addr <= addr_sub(row_addr, ADDR_W'(width));
            cnt <= cnt - RAD_W'(1);
          end else begin
            cur_addr <= row_addr;
            dx <= -$signed({1'b0, cur_job.left});
            dy <= -$signed({1'b0, cur_job.up});
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (dx == right_s) begin
            if (dy == down_s) begin
              state <= S_DRAIN;
            end else begin
              dy <= dy + OFF_W'(1);
              dx <= -$signed({1'b0, cur_job.left});
              row_addr <= addr_add(row_addr, ADDR_W'(width));
              cur_addr <= addr_add(row_addr, ADDR_W'(width));
            end
          end else begin
            dx <= dx + OFF_W'(1);
            cur_addr <= addr_add(cur_addr, ADDR_W'(1));
          end
        end
        S_DRAIN: begin
          if (!busy) begin
            for (int k = 0; k < 3; k++) begin
              rem[k] <= num[k];
              sat[k] <= num[k] >= {1'b0, wsum, 8'd0};
            end
            dv <= {wsum, 7'd0};
            zero <= wsum == '0;
            step <= 3'd7;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          for (int k = 0; k < 3; k++) begin
            if (rem[k] >= NUM_W'(dv)) begin
              rem[k] <= rem[k] - NUM_W'(dv);
              qv[k] <= {qv[k][6:0], 1'b1};
            end else begin
              qv[k] <= {qv[k][6:0], 1'b0};
            end
          end
          dv <= dv >> 1;
          step <= step - 3'd1;
          if (step == 3'd0) state <= S_EMIT;
        end
        S_EMIT: begin
          if (!results.valid || results.ready) begin
            results.valid <= 1'b1;
            results.blue_out <= res[0];
            results.green_out <= res[1];
            results.red_out <= res[2];
            results.frame_last <= cur_job.last;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_scan_feeds_pipe: assert property (@(posedge clk) disable iff (rst)
    v0 |-> $past(state == S_SCAN))
    else $error("window read without scan");

  a_div_after_drain: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> !(v1 || v2 || v3 || v4 || v5))
    else $error("divide started before accumulation finished");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state == S_EMIT))
    else $error("result raised outside emit");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop && job.cmp |=> state == S_PREP)
    else $error("window job not started");

endmodule

`default_nettype wire

// ===== rtl/core/bilateral_filter_rgb.sv =====
// ----------------------------------------------------------------------------
// bilateral_filter_rgb
// Streaming BGR bilateral filter with line store and weighted window average.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  pixels   in   valid/ready    operation, blue_in, green_in, red_in
//  results  out  valid/ready    blue_out, green_out, red_out, frame_last
//  cfg      in   valid/ready    index, data
//
// Each output passes through the window engine in order: it takes the job, sets
// up, walks up through the rows above the centre (up to 5), reads one neighbour
// per cycle across the clipped window (up to 121 neighbours), drains the weight
// pipeline, runs 8 divider steps and emits the result.
// Input items are taken once a cycle while the job queue has room.
// Reset is synchronous and clears control state; the store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module bilateral_filter_rgb (
  input  logic      clk,
  input  logic      rst,
  bfr_in_if.sink    pixels,
  bfr_out_if.source results,
  bfr_cfg_if.sink   cfg
);
  import bfr_pkg::*;

  logic [10:0] frame_width;
  logic [20:0] frame_height;
  logic [15:0] spatial_coef, range_coef;
  logic [COL_W-1:0] width;
  logic [ROW_W-1:0] height;

  logic     q_full, q_push, q_pop, q_valid;
  bfr_job_t push_job, pop_job;

  assign cfg.ready = 1'b1;

  always_comb begin
    if (frame_width == '0) width = COL_W'(1);
    else if (32'(frame_width) > MAX_WIDTH) width = COL_W'(MAX_WIDTH);
    else width = COL_W'(frame_width);
    if (frame_height == '0) height = ROW_W'(1);
    else if (32'(frame_height) > MAX_HEIGHT) height = ROW_W'(MAX_HEIGHT);
    else height = ROW_W'(frame_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 11'd640;
      frame_height <= 21'd480;
      spatial_coef <= 16'd2048;
      range_coef <= 16'd32;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_WIDTH: frame_width <= cfg.data[10:0];
        REG_FRAME_HEIGHT: frame_height <= cfg.data[20:0];
        REG_SPATIAL_COEF: spatial_coef <= cfg.data[15:0];
        REG_RANGE_COEF: range_coef <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  bfr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels),
    .width  (width),
    .height (height),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  bfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_job   (pop_job)
  );

  bfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .job          (pop_job),
    .q_pop        (q_pop),
    .width        (width),
    .spatial_coef (spatial_coef),
    .range_coef   (range_coef),
    .results      (results)
  );

endmodule

`default_nettype wire
